// File: hw/rtl/i2cwm_pkg.sv
`timescale 1ns / 1ps

package i2cwm_pkg;

    localparam int unsigned PHASE_W   = 16;
    localparam int unsigned TIMEOUT_W = 8;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned BYTE_W    = 8;

    localparam logic [PHASE_W-1:0]   PHASE_TICKS_RST = 16'd5;
    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;

    typedef enum logic {
        CFG_PHASE_TICKS = 1'b0,
        CFG_ACK_TIMEOUT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_POINTER = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_START1 = 5'd1,
        ST_START2 = 5'd2,
        ST_START3 = 5'd3,
        ST_TXL    = 5'd4,
        ST_TXH    = 5'd5,
        ST_ACK1   = 5'd6,
        ST_ACK2   = 5'd7,
        ST_POLL   = 5'd8,
        ST_RXL    = 5'd9,
        ST_RXH    = 5'd10,
        ST_MACK1  = 5'd11,
        ST_MACK2  = 5'd12,
        ST_MACK3  = 5'd13,
        ST_STOP1  = 5'd14,
        ST_STOP2  = 5'd15,
        ST_STOP3  = 5'd16,
        ST_ESTOP1 = 5'd17,
        ST_ESTOP2 = 5'd18,
        ST_ESTOP3 = 5'd19,
        ST_DONE   = 5'd20,
        ST_DONEE  = 5'd21
    } t_step;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        logic              err;
        logic [WORD_W-1:0] read_word;
    } t_bus_out;

endpackage

// File: hw/rtl/i2cwm_seq.sv
`timescale 1ns / 1ps

module i2cwm_seq
    import i2cwm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [PHASE_W-1:0]   i_phase_ticks,
    input  logic [TIMEOUT_W-1:0] i_ack_timeout,
    input  logic [1:0]           i_action,
    input  logic [BYTE_W-1:0]    i_dev_addr,
    input  logic [BYTE_W-1:0]    i_reg_addr,
    input  logic [WORD_W-1:0]    i_write_data,
    input  logic                 i_sda_in,
    output t_bus_out             o_bus
);

    t_step               r_step,  n_step;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [3:0]          r_bit,   n_bit;
    logic [1:0]          r_byte,  n_byte;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic [BYTE_W-1:0]   r_poll,  n_poll;
    logic [WORD_W-1:0]   r_accum, n_accum;
    t_action             r_act,   n_act;
    logic [BYTE_W-1:0]   r_dev,   n_dev;
    logic [BYTE_W-1:0]   r_reg,   n_reg;
    logic [WORD_W-1:0]   r_data,  n_data;

    logic [PHASE_W-1:0]  w_pt;
    logic                w_ph_last;
    logic [PHASE_W-1:0]  w_phase_adv;
    logic [2:0]          w_total;
    logic [1:0]          w_next_byte;
    logic [BYTE_W-1:0]   w_tx_next;
    logic [BYTE_W-1:0]   w_tx_first;
    logic [3:0]          w_bit_inc;
    logic [BYTE_W:0]     w_poll_inc;

    // A zero phase length runs as one tick per phase.
    assign w_pt        = (i_phase_ticks == '0) ? PHASE_W'(1) : i_phase_ticks;
    assign w_ph_last   = ({1'b0, r_phase} + (PHASE_W+1)'(1)) >= {1'b0, w_pt};
    assign w_phase_adv = w_ph_last ? '0 : r_phase + PHASE_W'(1);
    assign w_bit_inc   = r_bit + 4'd1;
    assign w_poll_inc  = {1'b0, r_poll} + (BYTE_W+1)'(1);
    assign w_next_byte = r_byte + 2'd1;

    always_comb begin
        case (r_act)
            ACT_WRITE:   w_total = 3'd4;
            ACT_POINTER: w_total = 3'd2;
            default:     w_total = 3'd1;
        endcase
    end

    always_comb begin
        if (r_act == ACT_READ) begin
            w_tx_first = r_dev + BYTE_W'(1);
        end else begin
            w_tx_first = r_dev;
        end
    end

    always_comb begin
        if (r_act == ACT_READ) begin
            w_tx_next = r_dev + BYTE_W'(1);
        end else begin
            case (w_next_byte)
                2'd0:    w_tx_next = r_dev;
                2'd1:    w_tx_next = r_reg;
                2'd2:    w_tx_next = r_data[WORD_W-1:BYTE_W];
                default: w_tx_next = r_data[BYTE_W-1:0];
            endcase
        end
    end

    // Bus drive and status for the current step.
    always_comb begin
        o_bus           = '0;
        o_bus.scl       = 1'b1;
        o_bus.sda       = 1'b1;
        o_bus.busy      = 1'b1;
        o_bus.read_word = r_accum;
        case (r_step)
            ST_START2: o_bus.sda = 1'b0;
            ST_START3: begin
                o_bus.scl = 1'b0;
                o_bus.sda = 1'b0;
            end
            ST_TXL: begin
                o_bus.scl = 1'b0;
                o_bus.sda = r_shift[BYTE_W-1];
            end
            ST_TXH:  o_bus.sda = r_shift[BYTE_W-1];
            ST_ACK1: o_bus.scl = 1'b0;
            ST_RXL:  o_bus.scl = 1'b0;
            ST_MACK1, ST_MACK3: begin
                o_bus.scl = 1'b0;
                o_bus.sda = (r_byte != 2'd0);
            end
            ST_MACK2: o_bus.sda = (r_byte != 2'd0);
            ST_STOP1, ST_ESTOP1: begin
                o_bus.scl = 1'b0;
                o_bus.sda = 1'b0;
            end
            ST_STOP2, ST_ESTOP2: o_bus.sda = 1'b0;
            ST_POLL, ST_ACK2, ST_RXH, ST_START1, ST_STOP3, ST_ESTOP3: ;
            ST_DONE: begin
                o_bus.busy = 1'b0;
                o_bus.done = 1'b1;
            end
            ST_DONEE: begin
                o_bus.busy = 1'b0;
                o_bus.done = 1'b1;
                o_bus.err  = 1'b1;
            end
            default: o_bus.busy = 1'b0;
        endcase
    end

    always_comb begin
        n_step  = r_step;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_accum = r_accum;
        n_act   = r_act;
        n_dev   = r_dev;
        n_reg   = r_reg;
        n_data  = r_data;
        case (r_step)
            ST_START1: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_START2;
            end
            ST_START2: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_START3;
            end
            ST_START3: begin
                n_phase = w_phase_adv;
                if (w_ph_last) begin
                    n_byte  = 2'd0;
                    n_shift = w_tx_first;
                    n_bit   = 4'd0;
                    n_step  = ST_TXL;
                end
            end
            ST_TXL: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_TXH;
            end
            ST_TXH: begin
                n_phase = w_phase_adv;
                if (w_ph_last) begin
                    n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                    n_bit   = w_bit_inc;
                    n_step  = (w_bit_inc >= 4'd8) ? ST_ACK1 : ST_TXL;
                end
            end
            ST_ACK1: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_ACK2;
            end
            ST_ACK2: begin
                n_phase = w_phase_adv;
                if (w_ph_last) begin
                    n_poll = '0;
                    n_step = ST_POLL;
                end
            end
            ST_POLL: begin
                n_phase = '0;
                if (!i_sda_in) begin
                    if ({1'b0, w_next_byte} < w_total && w_next_byte != 2'd0) begin
                        n_byte  = w_next_byte;
                        n_shift = w_tx_next;
                        n_bit   = 4'd0;
                        n_step  = ST_TXL;
                    end else if (r_act == ACT_READ) begin
                        n_byte = 2'd0;
                        n_bit  = 4'd0;
                        n_step = ST_RXL;
                    end else begin
                        n_step = ST_STOP1;
                    end
                end else if (w_poll_inc > {1'b0, i_ack_timeout}) begin
                    if (r_act == ACT_READ) n_accum = '0;
                    n_step = ST_ESTOP1;
                end else begin
                    n_poll = w_poll_inc[BYTE_W-1:0];
                end
            end
            ST_RXL: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_RXH;
            end
            ST_RXH: begin
                n_phase = w_phase_adv;
                if (w_ph_last) begin
                    n_accum = {r_accum[WORD_W-2:0], i_sda_in};
                    n_bit   = w_bit_inc;
                    n_step  = (w_bit_inc >= 4'd8) ? ST_MACK1 : ST_RXL;
                end
            end
            ST_MACK1: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_MACK2;
            end
            ST_MACK2: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_MACK3;
            end
            ST_MACK3: begin
                n_phase = w_phase_adv;
                if (w_ph_last) begin
                    if (r_byte == 2'd0) begin
                        n_byte = 2'd1;
                        n_bit  = 4'd0;
                        n_step = ST_RXL;
                    end else begin
                        n_step = ST_STOP1;
                    end
                end
            end
            ST_STOP1: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_STOP2;
            end
            ST_STOP2: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_STOP3;
            end
            ST_STOP3: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_DONE;
            end
            ST_ESTOP1: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_ESTOP2;
            end
            ST_ESTOP2: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_ESTOP3;
            end
            ST_ESTOP3: begin
                n_phase = w_phase_adv;
                if (w_ph_last) n_step = ST_DONEE;
            end
            default: begin
                n_phase = '0;
                if (t_action'(i_action) == ACT_TICK) begin
                    n_step = ST_IDLE;
                end else begin
                    n_act   = t_action'(i_action);
                    n_dev   = i_dev_addr;
                    n_reg   = i_reg_addr;
                    n_data  = i_write_data;
                    n_bit   = 4'd0;
                    n_byte  = 2'd0;
                    n_poll  = '0;
                    n_shift = '0;
                    if (t_action'(i_action) == ACT_READ) n_accum = '0;
                    n_step  = ST_START1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_IDLE;
            r_phase <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_shift <= '0;
            r_poll  <= '0;
            r_accum <= '0;
            r_act   <= ACT_TICK;
            r_dev   <= '0;
            r_reg   <= '0;
            r_data  <= '0;
        end else if (i_step) begin
            r_step  <= n_step;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_poll  <= n_poll;
            r_accum <= n_accum;
            r_act   <= n_act;
            r_dev   <= n_dev;
            r_reg   <= n_reg;
            r_data  <= n_data;
        end
    end

endmodule

// File: hw/rtl/i2c_register_word_master.sv
`timescale 1ns / 1ps

// Bit-level I2C master for 16-bit register writes, pointer sets and word reads. Every
// accepted item is one bus tick: it carries the sampled SDA level and, while the master
// is idle, an optional command, and it yields exactly one result item holding the SCL and
// SDA drive, busy, done, error and the last read word as they stood at the start of that
// tick. The sequencer advances once per accepted item, so one item is taken every clock
// cycle while results are taken; the result register decouples the sides, and a new item
// is accepted whenever that register is empty or its item is taken in the same cycle.
// Configuration registers hold the SCL phase length in ticks and the ACK poll timeout.

module i2c_register_word_master
    import i2cwm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_action,
    input  logic [BYTE_W-1:0]    i_dev_addr,
    input  logic [BYTE_W-1:0]    i_reg_addr,
    input  logic [WORD_W-1:0]    i_write_data,
    input  logic                 i_sda_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_scl_level,
    output logic                 o_sda_level,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic                 o_ack_error,
    output logic [WORD_W-1:0]    o_read_word
);

    logic [PHASE_W-1:0]   r_phase_ticks;
    logic [TIMEOUT_W-1:0] r_ack_timeout;
    logic                 r_out_valid, n_out_valid;
    t_bus_out             r_out;
    t_bus_out             w_bus;
    logic                 w_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    i2cwm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_accept),
        .i_phase_ticks (r_phase_ticks),
        .i_ack_timeout (r_ack_timeout),
        .i_action      (i_action),
        .i_dev_addr    (i_dev_addr),
        .i_reg_addr    (i_reg_addr),
        .i_write_data  (i_write_data),
        .i_sda_in      (i_sda_in),
        .o_bus         (w_bus)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_wdata[PHASE_W-1:0];
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_wdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_bus;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_out.scl;
    assign o_sda_level = r_out.sda;
    assign o_busy_res  = r_out.busy;
    assign o_done_res  = r_out.done;
    assign o_ack_error = r_out.err;
    assign o_read_word = r_out.read_word;

endmodule

// File: hw/rtl/i2cwm_checker.sv
`timescale 1ns / 1ps

module i2cwm_checker
    import i2cwm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic [1:0]           i_action,
    input  logic [BYTE_W-1:0]    i_dev_addr,
    input  logic [BYTE_W-1:0]    i_reg_addr,
    input  logic [WORD_W-1:0]    i_write_data,
    input  logic                 i_sda_in,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic                 o_scl_level,
    input  logic                 o_sda_level,
    input  logic                 o_busy_res,
    input  logic                 o_done_res,
    input  logic                 o_ack_error,
    input  logic [WORD_W-1:0]    o_read_word
);

    // A stalled result item holds its read word and its busy and done flags.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_word)
            && $stable(o_busy_res) && $stable(o_done_res))
        else $error("result item changed while stalled");

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // An error is only reported on a done tick.
    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ack_error |-> o_done_res && !o_busy_res)
        else $error("ack error outside a done tick");

    // When not busy the bus lines are released.
    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_scl_level && o_sda_level)
        else $error("bus driven while not busy");

endmodule

bind i2c_register_word_master i2cwm_checker u_i2cwm_checker (.*);
